[design/mllg_pkg.sv]
// Shared constants, types and helpers for the mixture gradient block.
package mllg_pkg;
  localparam int MAX_COMPONENTS = 6;
  localparam int FRAC_BITS      = 16;
  localparam int FIELD_W        = FRAC_BITS + 1;
  localparam int DOT_W          = 2 * FIELD_W + 3;
  localparam int RECIP_W        = 2 * FRAC_BITS;
  localparam int SUM_W          = 48;
  localparam int QBITS          = 3 * FRAC_BITS + 1;
  localparam int CNT_W          = $clog2(QBITS + 1);
  localparam int CFG_W          = FIELD_W;
  localparam int IDX_W          = 3;

  localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd0;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [SUM_W-1:0]   sum_t;

  // Per-lane control from the sequencer.
  typedef struct packed {
    logic                    accum;
    logic                    clear;
    logic [RECIP_W-1:0]      recip;
  } lane_ctl_t;

  // Clamp the active count into the legal range.
  function automatic logic [2:0] clamp_active(input logic [2:0] n);
    logic [2:0] r;
    r = n;
    if (n < 3'd2) r = 3'd2;
    if (n > 3'(MAX_COMPONENTS)) r = 3'(MAX_COMPONENTS);
    return r;
  endfunction
endpackage

[design/mllg_lane.sv]
// One population lane: product term and saturating accumulator.
module mllg_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                active,
  input  mllg_pkg::field_t    freq,
  input  mllg_pkg::lane_ctl_t ctl,
  output mllg_pkg::sum_t      sum,
  output logic                sat
);
  import mllg_pkg::*;

  logic [FIELD_W+RECIP_W-1:0] prod;
  logic [SUM_W:0]             total;

  // Exact term: floor(freq*recip / 2^F).
  assign prod  = FIELD_W'(freq) * (FIELD_W+RECIP_W)'(ctl.recip);
  assign total = {1'b0, sum} + (SUM_W+1)'(prod >> FRAC_BITS);
  assign sat   = ctl.accum && active && total[SUM_W];

  // Accumulate, saturating at full scale.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum <= '0;
    end else if (ctl.accum && active) begin
      sum <= total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
    end
  end
endmodule

[design/mllg_divider.sv]
// Restoring divider for floor(2^(3F)/dot), one quotient bit per cycle.
module mllg_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mllg_pkg::DOT_W-1:0]        dot,
  output logic                              done,
  output logic [mllg_pkg::RECIP_W-1:0]      quot
);
  import mllg_pkg::*;

  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DOT_W:0]     rem;
  logic [DOT_W-1:0]   dsr;
  logic [DOT_W:0]     shifted;
  logic [QBITS-1:0]   q;

  assign shifted = {rem[DOT_W-1:0], (cnt == CNT_W'(QBITS))};
  assign quot    = q[RECIP_W-1:0];

  // Step one quotient bit each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QBITS);
        rem  <= '0;
        dsr  <= dot;
        q    <= '0;
      end else if (busy) begin
        if (shifted >= {1'b0, dsr}) begin
          rem <= shifted - {1'b0, dsr};
          q   <= {q[QBITS-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[QBITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[design/mixture_log_likelihood_gradient.sv]
// Top level: mixture-proportion log-likelihood gradient accumulator.
//
// Loci arrive on the input channel (valid/stall); each carries six Q16
// frequencies and a last flag. Weights and the active count are set on the
// write port (index 0 active count, 1..6 weights); the user must write them
// only while idle, which the block itself does not enforce. After a locus
// is accepted the input stalls while the lane products are formed, the dot
// product is summed, the bit-serial reciprocal divider runs its quotient
// steps and gives its done strobe, and the six lanes accumulate. A tiny or
// zero dot product skips the divider, saturates the reciprocal and sets the
// flag. One locus is in flight at a time; input stall is high while busy.
// On a last locus an emit step loads the six sums and the flag into an
// output register and shows them with valid; the accumulators clear. If
// the receiver stalls, the result holds and the next locus is still
// accepted, but a later last locus waits until the pending result is taken.
// Reset clears sums, flag, output valid; active count returns to 2.
module mixture_log_likelihood_gradient (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mllg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mllg_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mllg_pkg::field_t             freq_0,
  input  mllg_pkg::field_t             freq_1,
  input  mllg_pkg::field_t             freq_2,
  input  mllg_pkg::field_t             freq_3,
  input  mllg_pkg::field_t             freq_4,
  input  mllg_pkg::field_t             freq_5,
  input  logic                         last_locus,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mllg_pkg::sum_t               grad_0,
  output mllg_pkg::sum_t               grad_1,
  output mllg_pkg::sum_t               grad_2,
  output mllg_pkg::sum_t               grad_3,
  output mllg_pkg::sum_t               grad_4,
  output mllg_pkg::sum_t               grad_5,
  output logic                         saturated
);
  import mllg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DOT, S_DIV, S_ACC, S_EMIT} state_t;

  state_t state;
  logic [2:0] active_reg;
  field_t     weight [MAX_COMPONENTS];
  field_t     freq   [MAX_COMPONENTS];
  logic [2*FIELD_W-1:0] wprod [MAX_COMPONENTS];
  logic       last_reg, sat_seen;
  logic [RECIP_W-1:0] recip;
  logic       div_start, div_done;
  logic [RECIP_W-1:0] div_q;
  logic [2:0] n_act;
  lane_ctl_t  ctl;
  sum_t       sums [MAX_COMPONENTS];
  logic [MAX_COMPONENTS-1:0] lane_sat, lane_act;
  logic       in_acc, out_acc;
  logic [DOT_W-1:0] dot_next;

  assign n_act    = clamp_active(active_reg);
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_reg <= 3'd2;
      for (int j = 0; j < MAX_COMPONENTS; j++) weight[j] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ACTIVE) active_reg <= cfg_data[2:0];
      else if (cfg_index <= IDX_W'(MAX_COMPONENTS))
        weight[cfg_index - 1'b1] <= cfg_data;
    end
  end

  // Sum active products.
  always_comb begin
    dot_next = '0;
    for (int j = 0; j < MAX_COMPONENTS; j++)
      if (3'(j) < n_act) dot_next = dot_next + DOT_W'(wprod[j]);
  end

  assign div_start = (state == S_DOT) && (dot_next > DOT_W'(1 << FRAC_BITS));

  mllg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dot(dot_next),
    .done(div_done), .quot(div_q)
  );

  // Sequencer with registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sat_seen  <= 1'b0;
    end else begin
      if (out_acc && (state != S_EMIT)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_acc) begin
          freq[0] <= freq_0; freq[1] <= freq_1; freq[2] <= freq_2;
          freq[3] <= freq_3; freq[4] <= freq_4; freq[5] <= freq_5;
          last_reg <= last_locus;
          state <= S_MUL;
        end
        S_MUL: begin
          for (int j = 0; j < MAX_COMPONENTS; j++) wprod[j] <= freq[j] * weight[j];
          state <= S_DOT;
        end
        S_DOT: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            recip    <= {RECIP_W{1'b1}};
            sat_seen <= 1'b1;
            state    <= S_ACC;
          end
        end
        S_DIV: if (div_done) begin
          recip <= div_q;
          state <= S_ACC;
        end
        S_ACC: begin
          if (|lane_sat) sat_seen <= 1'b1;
          state <= last_reg ? S_EMIT : S_IDLE;
        end
        S_EMIT: if (!out_valid || out_acc) begin
          grad_0 <= lane_act[0] ? sums[0] : '0;
          grad_1 <= lane_act[1] ? sums[1] : '0;
          grad_2 <= lane_act[2] ? sums[2] : '0;
          grad_3 <= lane_act[3] ? sums[3] : '0;
          grad_4 <= lane_act[4] ? sums[4] : '0;
          grad_5 <= lane_act[5] ? sums[5] : '0;
          saturated <= sat_seen;
          sat_seen  <= 1'b0;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ctl.accum = (state == S_ACC);
  assign ctl.clear = (state == S_EMIT) && (!out_valid || out_acc);
  assign ctl.recip = recip;

  // Lanes.
  for (genvar j = 0; j < MAX_COMPONENTS; j++) begin : g_lane
    assign lane_act[j] = (3'(j) < n_act);
    mllg_lane u_lane (
      .clk(clk), .rst(rst), .active(lane_act[j]), .freq(freq[j]),
      .ctl(ctl), .sum(sums[j]), .sat(lane_sat[j])
    );
  end

  // Checks.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(grad_0) && $stable(saturated)))
    else $error("result dropped under stall");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV)) else $error("divider done out of sequence");
endmodule

[tb/sv/tb_mixture_log_likelihood_gradient.sv]
// Self-checking testbench for the mixture gradient accumulator: directed table plus random loci.
`timescale 1ns / 100ps

module tb_mixture_log_likelihood_gradient;
  import mllg_pkg::*;

  typedef enum logic { ROW_CFG, ROW_LOCUS } row_kind_t;

  typedef struct packed {
    logic [5:0][SUM_W-1:0] g;
    logic                  sat;
  } grad_set_t;

  typedef struct {
    row_kind_t       kind;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    field_t          f [6];
    logic            last;
    logic            typed;
    grad_set_t       want;
  } stim_row_t;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [63:0]      RECIP_MAX = (64'd1 << RECIP_W) - 1;
  localparam int               DRAIN_CYC = 80;
  localparam int               WDOG_MAX  = 5000;

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0, in_stall;
  field_t freq_0 = '0, freq_1 = '0, freq_2 = '0, freq_3 = '0, freq_4 = '0, freq_5 = '0;
  logic last_locus = 1'b0;
  logic out_valid, out_stall = 1'b0, saturated;
  sum_t grad_0, grad_1, grad_2, grad_3, grad_4, grad_5;

  mixture_log_likelihood_gradient uut (.*);

  // Shadow of the block: configuration and running sums
  logic [2:0]       sh_active;
  logic [FIELD_W-1:0] sh_weight [6];
  logic [SUM_W-1:0] sh_sum [6];
  logic             sh_sat;

  grad_set_t pending_grads[$];
  stim_row_t rows[$];
  int errors = 0, loci_sent = 0, sums_checked = 0, cfg_writes = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Update the shadow for one locus; return the gradient set on a last locus
  function automatic bit predict_locus(input field_t f [6], input logic last,
                                       output grad_set_t res);
    int          n;
    logic [63:0] dot, recip, rhi, rlo, term, s;
    n = (sh_active < 3'd2) ? 2 : (sh_active > 3'(MAX_COMPONENTS)) ? MAX_COMPONENTS
        : int'(sh_active);
    dot = 0;
    for (int j = 0; j < n; j++) dot += 64'(f[j]) * 64'(sh_weight[j]);
    if (dot <= (64'd1 << FRAC_BITS)) begin
      recip = RECIP_MAX;
      sh_sat = 1'b1;
    end else begin
      recip = (64'd1 << (3 * FRAC_BITS)) / dot;
    end
    rhi = recip >> FRAC_BITS;
    rlo = recip & ((64'd1 << FRAC_BITS) - 1);
    for (int j = 0; j < n; j++) begin
      term = 64'(f[j]) * rhi + ((64'(f[j]) * rlo) >> FRAC_BITS);
      s = 64'(sh_sum[j]) + term;
      if (s > 64'(SUM_MAX)) begin
        s = 64'(SUM_MAX);
        sh_sat = 1'b1;
      end
      sh_sum[j] = s[SUM_W-1:0];
    end
    res = '0;
    if (!last) return 1'b0;
    for (int j = 0; j < 6; j++) begin
      res.g[j] = (j < n) ? sh_sum[j] : '0;
      sh_sum[j] = '0;
    end
    res.sat = sh_sat;
    sh_sat = 1'b0;
    return 1'b1;
  endfunction

  // Wait for all sums to drain, then let the divider finish any locus in flight
  task automatic wait_idle();
    while (pending_grads.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Register write, called at a falling edge while idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
    if (idx == REG_ACTIVE) sh_active = val[2:0];
    else if (idx <= 3'(MAX_COMPONENTS)) sh_weight[idx - 3'd1] = val;
  endtask

  // Present one locus request, hold until accepted, then leave a random gap
  task automatic send_locus(input field_t f [6], input logic last, input logic typed,
                            input grad_set_t want);
    grad_set_t pred;
    int        gap;
    in_valid = 1'b1;
    {freq_0, freq_1, freq_2, freq_3, freq_4, freq_5} = {f[0], f[1], f[2], f[3], f[4], f[5]};
    last_locus = last;
    do @(posedge clk); while (in_stall);
    if (predict_locus(f, last, pred)) pending_grads.push_back(typed ? want : pred);
    loci_sent++;
    @(negedge clk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 9) == 0)
          ? $urandom_range(10, 40) : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic void add_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.idx = idx;
    r.data = val;
    rows.push_back(r);
  endfunction

  function automatic void add_loc(input int a, b, c, d, e, g, input logic last,
                                  input logic typed = 1'b0, input grad_set_t want = '0);
    stim_row_t r;
    r = '{kind: ROW_LOCUS, default: '0};
    r.f = '{field_t'(a), field_t'(b), field_t'(c), field_t'(d), field_t'(e), field_t'(g)};
    r.last = last;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  function automatic field_t rand_freq();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return field_t'(1 << FRAC_BITS);
      2: return {FIELD_W{1'b1}};
      3: return field_t'($urandom_range(0, 255));
      default: return field_t'($urandom_range(0, 1 << FRAC_BITS));
    endcase
  endfunction

  // Receiver: random stall, mostly short, occasionally long
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each accepted gradient set with the oldest expectation
  always @(posedge clk) begin
    grad_set_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.g = {grad_5, grad_4, grad_3, grad_2, grad_1, grad_0};
      got.sat = saturated;
      if (pending_grads.size() == 0) begin
        $error("unexpected gradient set: grad_0=%0d saturated=%0b", got.g[0], got.sat);
        errors++;
      end else begin
        want = pending_grads.pop_front();
        sums_checked++;
        for (int j = 0; j < 6; j++)
          if (got.g[j] !== want.g[j]) begin
            $error("grad_%0d: expected %0d, got %0d", j, want.g[j], got.g[j]);
            errors++;
          end
        if (got.sat !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, got.sat);
          errors++;
        end
      end
    end
  end

  // Watchdog: abort when nothing is accepted for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired, %0d gradient sets outstanding", pending_grads.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    grad_set_t want, none;
    field_t    f [6];
    logic      prev_locus;
    int        run_len;
    none = '0;
    sh_active = 3'd2;
    for (int j = 0; j < 6; j++) begin
      sh_weight[j] = '0;
      sh_sum[j] = '0;
    end
    sh_sat = 1'b0;

    // Directed table: reset weights are zero, so the reciprocal saturates
    want = '0;
    want.g[0] = 48'hFFFF_FFFF;
    want.g[1] = 48'hFFFF_FFFF;
    want.sat = 1'b1;
    add_loc(65536, 65536, 65536, 65536, 65536, 65536, 1'b1, 1'b1, want);
    want = '0;
    want.sat = 1'b1;
    add_loc(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, want);
    // All six populations at weight one
    add_cfg(REG_ACTIVE, 17'd6);
    for (int i = 1; i <= 6; i++) add_cfg(IDX_W'(i), 17'd65536);
    add_loc(1, 0, 0, 0, 0, 0, 1'b0);          // dot at the 2^16 threshold: saturating boundary
    add_loc(2, 0, 0, 0, 0, 0, 1'b1);          // just above the boundary
    add_loc(131071, 131071, 131071, 131071, 131071, 131071, 1'b0);
    add_loc(65536, 65536, 65536, 65536, 65536, 65536, 1'b1);
    add_loc(0, 1, 65535, 65536, 131071, 12345, 1'b1);
    // Active count below range, weight above one, write to a missing register
    add_cfg(REG_ACTIVE, 17'd0);
    add_cfg(3'd1, 17'd0);
    add_cfg(3'd2, 17'd131071);
    add_cfg(3'd7, 17'd5);
    add_loc(131071, 131071, 131071, 131071, 131071, 131071, 1'b0);
    add_loc(1, 2, 3, 4, 5, 6, 1'b1);
    // Active count above range
    add_cfg(REG_ACTIVE, 17'd7);
    add_cfg(3'd6, 17'd0);
    add_cfg(3'd3, 17'd1);
    add_loc(40000, 30000, 20000, 10000, 5000, 131071, 1'b0);
    add_loc(65536, 0, 131071, 1, 65535, 7, 1'b1);
    add_cfg(REG_ACTIVE, 17'd1);
    add_loc(3, 131071, 0, 0, 0, 0, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the table; drop valid and drain before a register write that follows a locus
    prev_locus = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (prev_locus) begin
          in_valid = 1'b0;
          wait_idle();
        end
        write_reg(rows[i].idx, rows[i].data);
        prev_locus = 1'b0;
      end else begin
        send_locus(rows[i].f, rows[i].last, rows[i].typed, rows[i].want);
        prev_locus = 1'b1;
      end
    end

    // Random runs of loci, reconfiguring between some of them
    while (loci_sent < 750) begin
      if ($urandom_range(0, 2) == 0) begin
        in_valid = 1'b0;
        wait_idle();
        write_reg(REG_ACTIVE, CFG_W'($urandom_range(0, 7)));
        for (int i = 1; i <= 6; i++)
          write_reg(IDX_W'(i), ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 131071))
                                                          : CFG_W'($urandom_range(0, 65536)));
      end
      run_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
      for (int k = 0; k < run_len; k++) begin
        foreach (f[j]) f[j] = rand_freq();
        send_locus(f, k == run_len - 1, 1'b0, none);
      end
    end
    in_valid = 1'b0;
    last_locus = 1'b0;
    while (pending_grads.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("Sent %0d loci with %0d register writes; checked %0d gradient sets.",
             loci_sent, cfg_writes, sums_checked);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[sim.f]
design/mllg_pkg.sv
design/mllg_lane.sv
design/mllg_divider.sv
design/mixture_log_likelihood_gradient.sv
tb/sv/tb_mixture_log_likelihood_gradient.sv
